### rtl/core/mbd_pkg.sv
// Package: shared constants and types for the multi-button debouncer.
`timescale 1ns / 1ps
package mbd_pkg;

  localparam int unsigned NumButtonsDef = 4;
  localparam int unsigned CountWidthDef = 10;

  localparam int unsigned RegW = 10;

  localparam logic [RegW-1:0] PressSettleRst   = RegW'(80);
  localparam logic [RegW-1:0] SamplePeriodRst  = RegW'(50);
  localparam logic [RegW-1:0] ReleaseSettleRst = RegW'(50);

  typedef struct packed {
    logic press_ok;
    logic rel_seen;
  } lane_evt_t;

endpackage

### rtl/core/mbd_lane.sv
// Per-button debounce machine: phase, countdown and previous level of one button.
`timescale 1ns / 1ps
module mbd_lane #(
  parameter int unsigned COUNT_WIDTH = mbd_pkg::CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   level_i,
  input  logic [COUNT_WIDTH-1:0] press_load_i,
  input  logic [COUNT_WIDTH-1:0] sample_load_i,
  input  logic [COUNT_WIDTH-1:0] release_load_i,
  output mbd_pkg::lane_evt_t     evt_o
);
  import mbd_pkg::*;

  typedef enum logic [1:0] {
    PhWait,
    PhPress,
    PhSample,
    PhRelease
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   prev_q;
  logic                   expire;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign expire  = (cnt_q <= COUNT_WIDTH'(1));
  assign cnt_dec = expire ? '0 : (cnt_q - COUNT_WIDTH'(1));

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    evt_o   = '0;
    case (phase_q)
      PhWait: begin
        if (prev_q && !level_i) begin
          cnt_d   = press_load_i;
          phase_d = PhPress;
        end
      end
      PhPress: begin
        cnt_d = cnt_dec;
        if (expire) begin
          if (!level_i) begin
            evt_o.press_ok = 1'b1;
            cnt_d          = sample_load_i;
            phase_d        = PhSample;
          end else begin
            evt_o.rel_seen = 1'b1;
            phase_d        = PhWait;
          end
        end
      end
      PhSample: begin
        cnt_d = cnt_dec;
        if (expire) begin
          if (level_i) begin
            evt_o.rel_seen = 1'b1;
            cnt_d          = release_load_i;
            phase_d        = PhRelease;
          end else begin
            cnt_d = sample_load_i;
          end
        end
      end
      PhRelease: begin
        cnt_d = cnt_dec;
        if (expire) begin
          phase_d = PhWait;
        end
      end
      default: begin
        phase_d = PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWait;
      cnt_q   <= '0;
      prev_q  <= 1'b1;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      prev_q  <= level_i;
    end
  end

endmodule

### rtl/core/mbd_merge.sv
// Merge stage: gathers lane events into result vectors and buffers them with a skid slot.
`timescale 1ns / 1ps
module mbd_merge #(
  parameter int unsigned NUM_BUTTONS = mbd_pkg::NumButtonsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  mbd_pkg::lane_evt_t     evt_i [NUM_BUTTONS],
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [NUM_BUTTONS-1:0] press_confirmed_o,
  output logic [NUM_BUTTONS-1:0] release_seen_o,
  output logic                   full_o
);
  import mbd_pkg::*;

  logic [NUM_BUTTONS-1:0] conf_vec, rel_vec;
  logic                   main_valid_q, skid_valid_q;
  logic [NUM_BUTTONS-1:0] main_conf_q, main_rel_q;
  logic [NUM_BUTTONS-1:0] skid_conf_q, skid_rel_q;
  logic                   out_fire;

  always_comb begin
    for (int unsigned b = 0; b < NUM_BUTTONS; b++) begin
      conf_vec[b] = evt_i[b].press_ok;
      rel_vec[b]  = evt_i[b].rel_seen;
    end
  end

  assign out_fire = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept_i) begin
        if (!main_valid_q || out_fire) begin
          main_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        main_conf_q <= skid_conf_q;
        main_rel_q  <= skid_rel_q;
      end
    end else if (accept_i) begin
      if (!main_valid_q || out_fire) begin
        main_conf_q <= conf_vec;
        main_rel_q  <= rel_vec;
      end else begin
        skid_conf_q <= conf_vec;
        skid_rel_q  <= rel_vec;
      end
    end
  end

  assign out_valid_o       = main_valid_q;
  assign press_confirmed_o = main_conf_q;
  assign release_seen_o    = main_rel_q;
  assign full_o            = skid_valid_q;

endmodule

### rtl/core/multi_button_debounce_fsm.sv
// Top level: multi-button debouncer with configuration port, button lanes and result merge.
//
// Usage:
//   Each input item is one timer tick carrying the active-low levels of all
//   buttons on button_levels_i; it is taken when in_valid_i is high and
//   in_stall_o is low. Every tick yields exactly one result item on the
//   output channel: press_confirmed_o and release_seen_o, one bit per button.
//   The result is registered in the result register or, if that is held, the
//   skid slot. Throughput is one item per cycle while in_stall_o is low; the
//   result register is backed by a one-entry skid slot.
//   When the receiver holds out_stall_i, the result stays put and one more
//   item is still taken into the skid slot; in_stall_o then rises until the
//   slot drains.
//   Reset puts every button in the waiting phase with a zero countdown and a
//   released previous level, loads the settle and sample registers with
//   80, 50 and 50 ticks, and empties the output.
//   The APB port holds the three timing registers at byte addresses 0, 4, 8.
`timescale 1ns / 1ps
module multi_button_debounce_fsm #(
  parameter int unsigned NUM_BUTTONS = mbd_pkg::NumButtonsDef,
  parameter int unsigned COUNT_WIDTH = mbd_pkg::CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NUM_BUTTONS-1:0] button_levels_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [NUM_BUTTONS-1:0] press_confirmed_o,
  output logic [NUM_BUTTONS-1:0] release_seen_o
);
  import mbd_pkg::*;

  typedef enum logic [1:0] {
    RegPress   = 2'd0,
    RegSample  = 2'd1,
    RegRelease = 2'd2,
    RegNone    = 2'd3
  } reg_idx_e;

  localparam int unsigned LdW = (COUNT_WIDTH > RegW) ? COUNT_WIDTH : RegW;
  localparam logic [LdW-1:0] CntMax = LdW'((64'd1 << COUNT_WIDTH) - 64'd1);

  function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [RegW-1:0] r);
    logic [LdW-1:0] w;
    w = LdW'(r);
    if (w > CntMax) begin
      return '1;
    end
    return w[COUNT_WIDTH-1:0];
  endfunction

  logic [RegW-1:0]        press_q, sample_q, release_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;
  logic [COUNT_WIDTH-1:0] press_load, sample_load, release_load;
  logic                   in_accept;
  lane_evt_t              lane_evt [NUM_BUTTONS];
  logic                   skid_full;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= PressSettleRst;
      sample_q  <= SamplePeriodRst;
      release_q <= ReleaseSettleRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegPress:   press_q   <= pwdata[RegW-1:0];
        RegSample:  sample_q  <= pwdata[RegW-1:0];
        RegRelease: release_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegPress:   prdata = 32'(press_q);
      RegSample:  prdata = 32'(sample_q);
      RegRelease: prdata = 32'(release_q);
      default:    prdata = '0;
    endcase
  end

  assign press_load   = sat_load(press_q);
  assign sample_load  = sat_load(sample_q);
  assign release_load = sat_load(release_q);

  assign in_stall_o = skid_full;
  assign in_accept  = in_valid_i && !skid_full;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    mbd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .advance_i      (in_accept),
      .level_i        (button_levels_i[b]),
      .press_load_i   (press_load),
      .sample_load_i  (sample_load),
      .release_load_i (release_load),
      .evt_o          (lane_evt[b])
    );
  end

  mbd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_accept),
    .evt_i             (lane_evt),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .press_confirmed_o (press_confirmed_o),
    .release_seen_o    (release_seen_o),
    .full_o            (skid_full)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_no_double_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((press_confirmed_o & release_seen_o) == '0))
    else $error("button reports press and release in one item");

  a_stalled_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule

### dv/multi_button_debounce_fsm_test.sv
// Testbench: multi-button debouncer checked tick by tick against a behavioural predictor.
`timescale 1ns / 1ps
module multi_button_debounce_fsm_test;

  localparam int unsigned NB = mbd_pkg::NumButtonsDef;
  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [1:0] {
    BtnWaiting,
    BtnPressSettle,
    BtnSampling,
    BtnReleaseSettle
  } btn_phase_e;

  typedef enum int unsigned {
    RegPressSettle   = 0,
    RegSamplePeriod  = 1,
    RegReleaseSettle = 2,
    RegSpare         = 3
  } reg_idx_e;

  typedef struct packed {
    logic [NB-1:0] confirmed;
    logic [NB-1:0] released;
  } tick_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [3:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [NB-1:0] button_levels_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [NB-1:0] press_confirmed_o;
  logic [NB-1:0] release_seen_o;

  logic [9:0]    cfg_press;
  logic [9:0]    cfg_sample;
  logic [9:0]    cfg_release;
  btn_phase_e    btn_phase [NB];
  logic [9:0]    countdown [NB];
  logic [NB-1:0] prev_lvl;

  tick_result_t  pending_ticks [$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            tx_fast;
  bit            rx_fast;
  bit            rx_hold_req;
  logic [NB-1:0] gen_lv;
  int unsigned   hold_left [NB];

  multi_button_debounce_fsm i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .button_levels_i   (button_levels_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .press_confirmed_o (press_confirmed_o),
    .release_seen_o    (release_seen_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic count_expired(input int b);
    if (countdown[b] <= 10'd1) begin
      countdown[b] = '0;
      return 1'b1;
    end
    countdown[b] = countdown[b] - 10'd1;
    return 1'b0;
  endfunction

  task automatic debounce_tick(input logic [NB-1:0] lv, output tick_result_t res);
    res = '0;
    for (int b = 0; b < NB; b++) begin
      case (btn_phase[b])
        BtnWaiting: begin
          if (prev_lvl[b] && !lv[b]) begin
            countdown[b] = cfg_press;
            btn_phase[b] = BtnPressSettle;
          end
        end
        BtnPressSettle: begin
          if (count_expired(b)) begin
            if (!lv[b]) begin
              res.confirmed[b] = 1'b1;
              countdown[b] = cfg_sample;
              btn_phase[b] = BtnSampling;
            end else begin
              res.released[b] = 1'b1;
              btn_phase[b] = BtnWaiting;
            end
          end
        end
        BtnSampling: begin
          if (count_expired(b)) begin
            if (lv[b]) begin
              res.released[b] = 1'b1;
              countdown[b] = cfg_release;
              btn_phase[b] = BtnReleaseSettle;
            end else begin
              countdown[b] = cfg_sample;
            end
          end
        end
        default: begin
          if (count_expired(b)) btn_phase[b] = BtnWaiting;
        end
      endcase
      prev_lvl[b] = lv[b];
    end
  endtask

  always @(posedge clk_i) begin
    tick_result_t exp_res;
    tick_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        debounce_tick(button_levels_i, exp_res);
        pending_ticks.push_back(exp_res);
      end
      if (out_valid_o && !out_stall_i) begin
        got.confirmed = press_confirmed_o;
        got.released  = release_seen_o;
        if (pending_ticks.size() == 0) begin
          $display("%0t: result with no tick pending: press %h release %h",
                   $time, got.confirmed, got.released);
          error_count++;
        end else begin
          exp_res = pending_ticks.pop_front();
          if (got.confirmed !== exp_res.confirmed) begin
            $display("%0t: press_confirmed mismatch: expected %h, actual %h",
                     $time, exp_res.confirmed, got.confirmed);
            error_count++;
          end
          if (got.released !== exp_res.released) begin
            $display("%0t: release_seen mismatch: expected %h, actual %h",
                     $time, exp_res.released, got.released);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned wait_n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      wait_n = rx_fast ? 0 : $urandom_range(0, 13);
      if (rx_hold_req) begin
        wait_n = 60;
        rx_hold_req = 1'b0;
      end
      if (wait_n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (wait_n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_tick(input logic [NB-1:0] lv);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    button_levels_i <= lv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegPressSettle:   cfg_press   = val[9:0];
      RegSamplePeriod:  cfg_sample  = val[9:0];
      RegReleaseSettle: cfg_release = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_backpressure();
    tx_fast     = 1'b1;
    rx_hold_req = 1'b1;
    repeat (20) send_tick(NB'($urandom_range(0, 15)));
    tx_fast = 1'b0;
    wait_drained();
  endtask

  task automatic test_directed_presses();
    logic [NB-1:0] seq [] = '{4'hF, 4'h0, 4'h2, 4'h0, 4'h0, 4'h8, 4'h8, 4'h9, 4'hB,
                              4'hF, 4'hF, 4'h4, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'hF};
    write_reg(RegPressSettle, 32'd2);
    write_reg(RegSamplePeriod, 32'd2);
    write_reg(RegReleaseSettle, 32'd1);
    foreach (seq[i]) send_tick(seq[i]);
    wait_drained();
  endtask

  task automatic test_register_cases();
    logic [NB-1:0] seq [] = '{4'hF, 4'h0, 4'h0, 4'hF, 4'hF, 4'h0, 4'h5, 4'hF};
    write_reg(RegPressSettle, 32'd0);
    write_reg(RegSamplePeriod, 32'hFFFF_F001);
    write_reg(RegReleaseSettle, 32'h0000_0C03);
    write_reg(RegSpare, 32'h0000_0007);
    foreach (seq[i]) send_tick(seq[i]);
    wait_drained();
  endtask

  task automatic test_random_presses(input logic [31:0] p, input logic [31:0] s,
                                     input logic [31:0] r, input int unsigned n);
    int unsigned cap;
    write_reg(RegPressSettle, p);
    write_reg(RegSamplePeriod, s);
    write_reg(RegReleaseSettle, r);
    cap = 2 * (p[9:0] + s[9:0] + r[9:0]) + 4;
    if (cap > 250) cap = 250;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) tx_fast = !tx_fast;
      for (int b = 0; b < NB; b++) begin
        if (hold_left[b] == 0) begin
          gen_lv[b]    = !gen_lv[b];
          hold_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(1, cap);
        end
        hold_left[b]--;
      end
      if ($urandom_range(0, 19) == 0) send_tick(NB'($urandom_range(0, 15)));
      else send_tick(gen_lv);
      if (k == n / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    button_levels_i = '1;
    cfg_press       = mbd_pkg::PressSettleRst;
    cfg_sample      = mbd_pkg::SamplePeriodRst;
    cfg_release     = mbd_pkg::ReleaseSettleRst;
    prev_lvl        = '1;
    gen_lv          = '1;
    for (int b = 0; b < NB; b++) begin
      btn_phase[b] = BtnWaiting;
      countdown[b] = '0;
      hold_left[b] = 0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_backpressure();
    test_directed_presses();
    test_register_cases();
    test_random_presses(32'd3, 32'd2, 32'd2, 100);
    test_random_presses(32'd1, 32'd1, 32'd1, 80);
    test_random_presses(32'd80, 32'd50, 32'd50, 150);
    test_random_presses(32'd6, 32'd3, 32'd9, 80);
    test_random_presses(32'd1023, 32'd1023, 32'd1023, 40);

    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
